FILE: src/dmcl_pkg.sv
// ============================================================================
// dmcl_pkg
// Shared types and constants for the direct-mapped cache lookup block.
// ============================================================================
package dmcl_pkg;

    // Default geometry of the cache and of the address.
    localparam int DMCL_LINE_COUNT_LOG2 = 10;
    localparam int DMCL_ADDR_WIDTH      = 32;

    // Fixed field widths.
    localparam int TAG_W       = 32;
    localparam int LINE_OUT_W  = 10;
    localparam int OFFSET_W    = 31;
    localparam int COUNT_W     = 32;
    localparam int CYCLE_W     = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Register reset values.
    localparam logic [4:0] OFFSET_BITS_RST    = 5'd2;
    localparam logic [3:0] INDEX_BITS_RST     = 4'd10;
    localparam logic [7:0] MEMORY_LATENCY_RST = 8'd100;
    localparam logic [3:0] CACHE_LATENCY_RST  = 4'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS    = 2'd0,
        CFG_INDEX_BITS     = 2'd1,
        CFG_MEMORY_LATENCY = 2'd2,
        CFG_CACHE_LATENCY  = 2'd3
    } dmcl_cfg_idx_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } dmcl_state_t;

    // Statistics update request from the control logic.
    typedef struct packed {
        logic update;
        logic hit;
    } dmcl_stat_upd_t;

endpackage

FILE: src/direct_mapped_cache_lookup.sv
// ============================================================================
// direct_mapped_cache_lookup
// Direct-mapped cache tag lookup with saturating access statistics.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    address
// output    out        out_valid / out_stall  hit, tag_value, line_index,
//                                             byte_offset, hit_count,
//                                             miss_count, access_count,
//                                             cycle_total
// config    in         cfg_write              cfg_index, cfg_data
//
// Each address passes through a transfer cycle, which issues the tag memory
// read, and the lookup state, which compares the registered tag word, writes
// the line back on a miss and loads the result register once that register
// is empty or drains. The registered read data of the tag memory, with one
// address in lookup at a time, sets this sequence. After reset a clearing
// pass writes every line as invalid, with in_stall held high.
// A result waiting under out_stall does not block the next input transfer;
// only the lookup of that next address waits for the result register.
//
module direct_mapped_cache_lookup
    import dmcl_pkg::*;
#(
    parameter int LINE_COUNT_LOG2 = DMCL_LINE_COUNT_LOG2,
    parameter int ADDR_WIDTH      = DMCL_ADDR_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TAG_W-1:0]      address,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [TAG_W-1:0]      tag_value,
    output logic [LINE_OUT_W-1:0] line_index,
    output logic [OFFSET_W-1:0]   byte_offset,
    output logic [COUNT_W-1:0]    hit_count,
    output logic [COUNT_W-1:0]    miss_count,
    output logic [COUNT_W-1:0]    access_count,
    output logic [CYCLE_W-1:0]    cycle_total,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Geometry derived from the parameters. A zero-width index still needs
    // one address bit for the memory, which then has a single line.
    localparam int LINE_COUNT = 1 << LINE_COUNT_LOG2;
    localparam int IDX_W      = (LINE_COUNT_LOG2 > 0) ? LINE_COUNT_LOG2 : 1;
    localparam int WORD_W     = TAG_W + 1;
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(LINE_COUNT - 1);
    localparam logic [4:0]       MAX_IB     = 5'(LINE_COUNT_LOG2);
    localparam logic [63:0]      ADDR_MASK64 = (64'd1 << ADDR_WIDTH) - 64'd1;
    localparam logic [TAG_W-1:0] ADDR_MASK  = ADDR_MASK64[TAG_W-1:0];

    // Configuration registers.
    logic [4:0] off_width_reg;
    logic [3:0] idx_width_reg;
    logic [7:0] memory_latency_reg;
    logic [3:0] cache_latency_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_width_reg      <= OFFSET_BITS_RST;
            idx_width_reg      <= INDEX_BITS_RST;
            memory_latency_reg <= MEMORY_LATENCY_RST;
            cache_latency_reg  <= CACHE_LATENCY_RST;
        end
        else if (cfg_write)
        begin
            case (dmcl_cfg_idx_t'(cfg_index))
                CFG_OFFSET_BITS:    off_width_reg      <= cfg_data[4:0];
                CFG_INDEX_BITS:     idx_width_reg      <= cfg_data[3:0];
                CFG_MEMORY_LATENCY: memory_latency_reg <= cfg_data;
                CFG_CACHE_LATENCY:  cache_latency_reg  <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    // Address split. The index width is clamped to LINE_COUNT_LOG2, and the
    // tag is whatever lies above offset and index; a shift past the top of
    // the word leaves a zero tag.
    logic [TAG_W-1:0] addr_m;
    logic [4:0]       ib_eff;
    logic [5:0]       tag_shift;
    logic [TAG_W-1:0] off_w;
    logic [TAG_W-1:0] line_w;
    logic [TAG_W-1:0] tag_w;

    always_comb
    begin
        addr_m    = address & ADDR_MASK;
        ib_eff    = ({1'b0, idx_width_reg} > MAX_IB) ? MAX_IB : {1'b0, idx_width_reg};
        tag_shift = {1'b0, off_width_reg} + {1'b0, ib_eff};
        off_w     = addr_m & ~({TAG_W{1'b1}} << off_width_reg);
        line_w    = (addr_m >> off_width_reg) & ~({TAG_W{1'b1}} << ib_eff);
        tag_w     = addr_m >> tag_shift;
    end

    // Handshake and sequencer.
    dmcl_state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             in_xfer;
    logic             done;

    assign in_xfer = in_valid && !in_stall;

    // The lookup completes once the result register is empty or drains in
    // the same cycle.
    assign done = (state_reg == ST_LOOKUP) && (!out_valid || !out_stall);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Fields of the address in lookup, captured at the input transfer.
    logic [TAG_W-1:0]      tag_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [LINE_OUT_W-1:0] line_reg;
    logic [OFFSET_W-1:0]   off_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tag_reg  <= tag_w;
            slot_reg <= line_w[IDX_W-1:0];
            line_reg <= line_w[LINE_OUT_W-1:0];
            off_reg  <= off_w[OFFSET_W-1:0];
        end
    end

    // Tag memory: one valid bit above the stored tag.
    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              lookup_hit;
    dmcl_stat_upd_t    stat_upd;

    assign lookup_hit = ram_rdata[TAG_W] && (ram_rdata[TAG_W-1:0] == tag_reg);

    always_comb
    begin
        in_stall        = 1'b1;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = {1'b1, tag_reg};
        stat_upd.update = 1'b0;
        stat_upd.hit    = lookup_hit;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                // A miss installs the new tag; the next read of any line
                // comes no earlier than the following cycle, in the idle
                // state, so no bypass is needed.
                ram_we          = done && !lookup_hit;
                stat_upd.update = done;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    dmcl_tag_ram #(
        .IDX_W  (IDX_W),
        .DEPTH  (LINE_COUNT),
        .WORD_W (WORD_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (line_w[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // The counters change only when a result is loaded, so they always show
    // the totals after the result currently on the output.
    dmcl_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .upd            (stat_upd),
        .memory_latency (memory_latency_reg),
        .cache_latency  (cache_latency_reg),
        .hit_count      (hit_count),
        .miss_count     (miss_count),
        .access_count   (access_count),
        .cycle_total    (cycle_total)
    );

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg;
    logic [TAG_W-1:0]      out_tag_reg;
    logic [LINE_OUT_W-1:0] out_line_reg;
    logic [OFFSET_W-1:0]   out_off_reg;

    always_comb
    begin
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            hit_reg      <= lookup_hit;
            out_tag_reg  <= tag_reg;
            out_line_reg <= line_reg;
            out_off_reg  <= off_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign tag_value   = out_tag_reg;
    assign line_index  = out_line_reg;
    assign byte_offset = out_off_reg;

endmodule

FILE: src/dmcl_tag_ram.sv
// ============================================================================
// dmcl_tag_ram
// Single-port-write, single-port-read tag memory with registered read data.
// ============================================================================
module dmcl_tag_ram
    import dmcl_pkg::*;
#(
    parameter int IDX_W  = DMCL_LINE_COUNT_LOG2,
    parameter int DEPTH  = 1 << DMCL_LINE_COUNT_LOG2,
    parameter int WORD_W = TAG_W + 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [IDX_W-1:0]  raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dmcl_stats.sv
// ============================================================================
// dmcl_stats
// Saturating hit, miss, access and cycle counters.
// ============================================================================
module dmcl_stats
    import dmcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dmcl_stat_upd_t     upd,
    input  logic [7:0]         memory_latency,
    input  logic [3:0]         cache_latency,
    output logic [COUNT_W-1:0] hit_count,
    output logic [COUNT_W-1:0] miss_count,
    output logic [COUNT_W-1:0] access_count,
    output logic [CYCLE_W-1:0] cycle_total
);

    logic [COUNT_W-1:0] hit_reg, hit_next;
    logic [COUNT_W-1:0] miss_reg, miss_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [CYCLE_W-1:0] cyc_reg, cyc_next;
    logic [8:0]         cyc_inc;
    logic [CYCLE_W:0]   cyc_sum;

    always_comb
    begin
        // A miss pays for memory and cache, a hit for the cache alone.
        cyc_inc  = upd.hit ? {5'd0, cache_latency}
                           : {1'b0, memory_latency} + {5'd0, cache_latency};
        cyc_sum  = {1'b0, cyc_reg} + (CYCLE_W + 1)'(cyc_inc);
        hit_next  = hit_reg;
        miss_next = miss_reg;
        acc_next  = acc_reg;
        cyc_next  = cyc_reg;
        if (upd.update)
        begin
            if (upd.hit && (hit_reg != '1))
            begin
                hit_next = hit_reg + 1'b1;
            end
            if (!upd.hit && (miss_reg != '1))
            begin
                miss_next = miss_reg + 1'b1;
            end
            if (acc_reg != '1)
            begin
                acc_next = acc_reg + 1'b1;
            end
            cyc_next = cyc_sum[CYCLE_W] ? '1 : cyc_sum[CYCLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= '0;
            miss_reg <= '0;
            acc_reg  <= '0;
            cyc_reg  <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            miss_reg <= miss_next;
            acc_reg  <= acc_next;
            cyc_reg  <= cyc_next;
        end
    end

    assign hit_count    = hit_reg;
    assign miss_count   = miss_reg;
    assign access_count = acc_reg;
    assign cycle_total  = cyc_reg;

endmodule

FILE: src/dmcl_checker.sv
// ============================================================================
// dmcl_checker
// Port-level checks for the direct-mapped cache lookup block.
// ============================================================================
module dmcl_checker
    import dmcl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit,
    input logic [TAG_W-1:0]   tag_value,
    input logic [COUNT_W-1:0] hit_count,
    input logic [COUNT_W-1:0] miss_count,
    input logic [COUNT_W-1:0] access_count,
    input logic [CYCLE_W-1:0] cycle_total
);

    // One address is in lookup at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a lookup was in progress");

    // Until the access count saturates, every access is a hit or a miss.
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (access_count != '1)) |->
        ({1'b0, access_count} == ({1'b0, hit_count} + {1'b0, miss_count})))
        else $error("access count differs from hits plus misses");

    // A reported miss is counted.
    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (miss_count != '0))
        else $error("miss reported with a zero miss count");

    // Accumulated cycles never go down.
    a_cycles_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (cycle_total >= $past(cycle_total)))
        else $error("cycle total decreased");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(tag_value) && $stable(access_count)))
        else $error("stalled result changed");

endmodule

bind direct_mapped_cache_lookup dmcl_checker u_dmcl_checker (.*);

FILE: verif/tb_direct_mapped_cache_lookup.sv
// ============================================================================
// tb_direct_mapped_cache_lookup
// Self-checking testbench for the direct-mapped cache lookup block. A shadow
// copy of the tag store and the statistics counters predicts every lookup
// result; results are compared in order, field by field, as they leave.
// ============================================================================
module tb_direct_mapped_cache_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import dmcl_pkg::*;

    localparam int LINES_LOG2  = DMCL_LINE_COUNT_LOG2;
    localparam int LINES       = 1 << LINES_LOG2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_SETTING = 125;

    // Addresses that hit the extremes of every split field under the reset
    // geometry: cold misses, hits at the largest offset, conflicts on the
    // first and the last line, and alternating bit patterns.
    localparam logic [TAG_W-1:0] EDGE_ADDRS [13] = '{
        32'h0000_0000, 32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFC,
        32'h0000_1000, 32'h0000_0000, 32'h0000_0FFC, 32'hFFFF_FFFF,
        32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h5555_5555
    };

    // A short burst of extreme addresses repeated after each register change.
    localparam logic [TAG_W-1:0] SETTING_EDGES [3] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF
    };

    // One lookup result, in the order of the output ports.
    typedef struct packed {
        logic                  hit;
        logic [TAG_W-1:0]      tag;
        logic [LINE_OUT_W-1:0] line;
        logic [OFFSET_W-1:0]   offset;
        logic [COUNT_W-1:0]    hits;
        logic [COUNT_W-1:0]    misses;
        logic [COUNT_W-1:0]    accesses;
        logic [CYCLE_W-1:0]    cycles;
    } lookup_t;

    // The shadow cache mirrors the register file, the tag store and the
    // counters, and keeps the lookups whose results have not yet left.
    class cache_shadow;
        logic [4:0]         off_width;
        logic [3:0]         idx_width;
        logic [7:0]         memory_latency;
        logic [3:0]         cache_latency;
        bit                 line_valid [LINES];
        logic [TAG_W-1:0]   line_tag [LINES];
        logic [COUNT_W-1:0] hits_seen;
        logic [COUNT_W-1:0] misses_seen;
        logic [COUNT_W-1:0] accesses_seen;
        logic [CYCLE_W-1:0] cycles_spent;
        lookup_t            pending_lookups [$];
        int                 mismatches;
        int                 compared;

        function new();
            off_width      = OFFSET_BITS_RST;
            idx_width      = INDEX_BITS_RST;
            memory_latency = MEMORY_LATENCY_RST;
            cache_latency  = CACHE_LATENCY_RST;
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
            end
            hits_seen     = '0;
            misses_seen   = '0;
            accesses_seen = '0;
            cycles_spent  = '0;
            mismatches    = 0;
            compared      = 0;
        endfunction

        function void set_register(dmcl_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET_BITS:    off_width      = data[4:0];
                CFG_INDEX_BITS:     idx_width      = data[3:0];
                CFG_MEMORY_LATENCY: memory_latency = data[7:0];
                CFG_CACHE_LATENCY:  cache_latency  = data[3:0];
                default: ;
            endcase
        endfunction

        // Splits one accepted address, updates the tag store and the
        // saturating counters, and queues the result it must produce.
        function void note_address(logic [TAG_W-1:0] addr);
            int             ob;
            int             ib;
            logic [63:0]    wide;
            logic [63:0]    line;
            int             slot;
            logic [CYCLE_W:0] sum;
            lookup_t        r;
            ob   = off_width;
            ib   = (idx_width > LINES_LOG2) ? LINES_LOG2 : idx_width;
            wide = {32'd0, addr};
            line = (wide >> ob) & ((64'd1 << ib) - 64'd1);
            slot = int'(line & 64'(LINES - 1));
            r.offset = OFFSET_W'(wide & ((64'd1 << ob) - 64'd1));
            r.line   = LINE_OUT_W'(line);
            r.tag    = TAG_W'(wide >> (ob + ib));
            // An invalid line never compares its stored tag.
            r.hit = line_valid[slot] && (line_tag[slot] == r.tag);
            if (r.hit)
            begin
                if (hits_seen != '1)
                    hits_seen = hits_seen + 1'b1;
                sum = cycles_spent + cache_latency;
            end
            else
            begin
                line_valid[slot] = 1'b1;
                line_tag[slot]   = r.tag;
                if (misses_seen != '1)
                    misses_seen = misses_seen + 1'b1;
                sum = cycles_spent + memory_latency + cache_latency;
            end
            cycles_spent = sum[CYCLE_W] ? '1 : sum[CYCLE_W-1:0];
            if (accesses_seen != '1)
                accesses_seen = accesses_seen + 1'b1;
            r.hits     = hits_seen;
            r.misses   = misses_seen;
            r.accesses = accesses_seen;
            r.cycles   = cycles_spent;
            pending_lookups = {pending_lookups, r};
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_lookup(lookup_t got);
            lookup_t want;
            if (pending_lookups.size() == 0)
            begin
                report_mismatch($sformatf("result with no lookup outstanding, tag %0h",
                                          got.tag));
                return;
            end
            want = pending_lookups.pop_front();
            compared++;
            compare_field("hit", got.hit, want.hit);
            compare_field("tag_value", got.tag, want.tag);
            compare_field("line_index", got.line, want.line);
            compare_field("byte_offset", got.offset, want.offset);
            compare_field("hit_count", got.hits, want.hits);
            compare_field("miss_count", got.misses, want.misses);
            compare_field("access_count", got.accesses, want.accesses);
            compare_field("cycle_total", got.cycles, want.cycles);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [TAG_W-1:0]      address;
    logic                  out_valid;
    logic                  out_stall;
    logic                  hit;
    logic [TAG_W-1:0]      tag_value;
    logic [LINE_OUT_W-1:0] line_index;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [COUNT_W-1:0]    hit_count;
    logic [COUNT_W-1:0]    miss_count;
    logic [COUNT_W-1:0]    access_count;
    logic [CYCLE_W-1:0]    cycle_total;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cache_shadow      shadow;
    bit               gaps_on;
    int               cycle_count = 0;
    int               settings_run;
    logic [TAG_W-1:0] recent_addrs [$];

    direct_mapped_cache_lookup DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .tag_value    (tag_value),
        .line_index   (line_index),
        .byte_offset  (byte_offset),
        .hit_count    (hit_count),
        .miss_count   (miss_count),
        .access_count (access_count),
        .cycle_total  (cycle_total),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver stalls in about a third of the cycles while gaps are on.
    // Stall is decided at the falling edge, independent of out_valid.
    always @(negedge clk)
        out_stall <= gaps_on && ($urandom_range(0, 99) < 36);

    // Every rising edge advances the watchdog and, when a result transfer
    // takes place, hands the result to the shadow cache. Values are read
    // right at the edge, before the block's own registers update.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
            shadow.check_lookup(lookup_t'{hit, tag_value, line_index, byte_offset,
                                          hit_count, miss_count, access_count,
                                          cycle_total});
    end

    // Drives one address transfer. It is entered at a falling edge, may idle
    // first, then holds the address steady until the block takes it, and
    // returns at the next falling edge.
    task automatic send_access(input logic [TAG_W-1:0] addr);
        while (gaps_on && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            address  <= $urandom();
            @(negedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow.note_address(addr);
        recent_addrs = {recent_addrs, addr};
        if (recent_addrs.size() > 16)
            void'(recent_addrs.pop_front());
        @(negedge clk);
    endtask

    // Picks the next random address. Most addresses revisit a recent one,
    // either with a fresh offset (a likely hit) or with a new small tag on
    // the same line (a conflict miss); the rest are fully random.
    function automatic logic [TAG_W-1:0] next_address(int ob, int ib);
        int          roll;
        logic [63:0] pick;
        logic [63:0] keep;
        roll = $urandom_range(0, 99);
        if (recent_addrs.size() == 0 || roll >= 75)
            return $urandom();
        pick = {32'd0, recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]};
        if (roll < 45)
        begin
            keep = (64'd1 << ob) - 64'd1;
            return TAG_W'((pick & ~keep) | ({32'd0, $urandom()} & keep));
        end
        keep = (64'd1 << (ob + ib)) - 64'd1;
        return TAG_W'((pick & keep) | (64'($urandom_range(0, 3)) << (ob + ib)));
    endfunction

    // One register write; entered and left at a falling edge.
    task automatic write_register(input dmcl_cfg_idx_t idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        shadow.set_register(idx, data);
        @(negedge clk);
    endtask

    // Runs one register setting: waits for the block to drain, programs the
    // registers if asked, then sends the directed burst and the random part.
    task automatic run_setting(input logic [CFG_DATA_W-1:0] ob_data,
                               input logic [CFG_DATA_W-1:0] ib_data,
                               input logic [CFG_DATA_W-1:0] mem_data,
                               input logic [CFG_DATA_W-1:0] cache_data,
                               input bit program_regs,
                               input bit idle_gaps);
        int ob;
        int ib;
        in_valid <= 1'b0;
        while (shadow.pending_lookups.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (program_regs)
        begin
            write_register(CFG_OFFSET_BITS, ob_data);
            write_register(CFG_INDEX_BITS, ib_data);
            write_register(CFG_MEMORY_LATENCY, mem_data);
            write_register(CFG_CACHE_LATENCY, cache_data);
            cfg_write <= 1'b0;
        end
        gaps_on = idle_gaps;
        settings_run++;
        ob = shadow.off_width;
        ib = (shadow.idx_width > LINES_LOG2) ? LINES_LOG2 : shadow.idx_width;
        if (program_regs)
            foreach (SETTING_EDGES[i])
                send_access(SETTING_EDGES[i]);
        else
            foreach (EDGE_ADDRS[i])
                send_access(EDGE_ADDRS[i]);
        repeat (RANDOM_PER_SETTING)
            send_access(next_address(ob, ib));
    endtask

    initial
    begin
        shadow       = new();
        settings_run = 0;
        gaps_on      = 1'b1;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        address      = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_OFFSET_BITS;
        cfg_data     = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first addresses wait out the clearing pass under in_stall.
        run_setting(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        // Smallest fields and latencies: every address lands on line zero.
        run_setting(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
        // All-ones data: widest offset, index above the line count, and the
        // largest latencies.
        run_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        // A long stretch with neither side idling.
        run_setting(8'd4, 8'd6, 8'd37, 8'd3, 1'b1, 1'b0);
        // Index above the line count again, with stored tags from before.
        run_setting(8'd6, 8'd11, 8'd200, 8'd9, 1'b1, 1'b1);

        in_valid <= 1'b0;
        while (shadow.pending_lookups.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("covered %0d lookups over %0d register settings: %0d hits, %0d misses",
                 shadow.accesses_seen, settings_run, shadow.hits_seen, shadow.misses_seen);
        $display("%0d results compared, %0d mismatches", shadow.compared,
                 shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
